[hw/rtl/dosp_pkg.sv]
// ----------------------------------------------------------------------------
// DHCP option stream parser package
// Shared types and constants for the option parser: packet layout, option
// codes, the per-byte input transaction and the result transaction.
// ----------------------------------------------------------------------------
package dosp_pkg;

  // Largest packet that is walked; bytes at or beyond it are ignored.
  localparam int unsigned MAX_PACKET_BYTES = 1024;
  // Byte position saturates at MAX_PACKET_BYTES, so it must hold that value.
  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);

  localparam int unsigned FIXED_HEADER_BYTES = 236;
  localparam int unsigned COOKIE_BYTES       = 4;
  localparam int unsigned OFFSET_W           = 10;

  localparam logic [7:0] CODE_PAD          = 8'd0;
  localparam logic [7:0] CODE_END          = 8'd255;
  localparam logic [7:0] CODE_MESSAGE_TYPE = 8'd53;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_COOKIE,
    PH_TYPE,
    PH_LENGTH,
    PH_DATA,
    PH_DONE,
    PH_DISCARD,
    PH_OVERRUN
  } phase_e;

  typedef enum logic {
    KIND_RECORD,
    KIND_VERDICT
  } kind_e;

  typedef enum logic [2:0] {
    VERDICT_OK,
    VERDICT_TOO_SHORT,
    VERDICT_BAD_COOKIE,
    VERDICT_OVERRUN,
    VERDICT_NO_MSG_TYPE
  } verdict_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            option_type;
    logic [7:0]            option_length;
    logic [OFFSET_W-1:0]   data_offset;
    verdict_e              verdict;
  } out_item_t;

  // Expected magic cookie byte for each of the four cookie positions.
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0:    val = 8'd99;
      2'd1:    val = 8'd130;
      2'd2:    val = 8'd83;
      default: val = 8'd99;
    endcase
    return val;
  endfunction

endpackage

[hw/rtl/dhcp_option_stream_parser.sv]
// ----------------------------------------------------------------------------
// DHCP option stream parser
// Walks the options of a received DHCP packet and reports each option and
// a final verdict for the packet.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one packet byte per transaction, header first,
//   with last_byte set on the final byte. The parser skips the fixed header,
//   checks the magic cookie and walks the type-length-value options.
//   The output channel gives one record per option other than pad and end
//   (on the option's length byte) and one verdict transaction on the last
//   byte of each packet. Bytes that cause no result are consumed silently.
// Timing:
//   One byte is accepted per cycle while the skid entry is empty. A result is
//   registered in the output register, or in the skid entry while the output
//   is stalled; the state update for a byte is a single pass of logic between
//   the parser state registers and the result register.
// Stalls and reset:
//   An output register plus one skid entry hold results; the input is
//   stalled only while the skid entry is occupied, so one byte may still be
//   taken while a result waits. Reset (rst_ni low) clears the parser to the
//   start of a packet and empties the output stage. After a verdict the
//   parser is again at the start of a packet.
// ----------------------------------------------------------------------------
module dhcp_option_stream_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dosp_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dosp_pkg::out_item_t out_data_o
);
  import dosp_pkg::*;

  // Parser state.
  logic [POS_W-1:0] pos_q, pos_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       skip_q, skip_d;
  logic [7:0]       type_q, type_d;
  logic             cookie_ok_q, cookie_ok_d;
  logic             seen_mt_q, seen_mt_d;

  // State after processing the current byte, before the end-of-packet clear.
  logic [POS_W-1:0] pos_s;
  phase_e           phase_s;
  logic [7:0]       skip_s;
  logic [7:0]       type_s;
  logic             cookie_ok_s;
  logic             seen_mt_s;
  logic             record_s;

  // Output stage.
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t skid_q, skid_d;

  logic      in_accept;
  logic      res_valid;
  out_item_t res;
  logic      out_free;
  logic [7:0] b;
  logic [1:0] cookie_idx;

  assign b          = in_data_i.data_byte;
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cookie_idx = 2'(pos_q - POS_W'(FIXED_HEADER_BYTES));

  // Per-byte parser step.
  always_comb begin
    pos_s       = pos_q;
    phase_s     = phase_q;
    skip_s      = skip_q;
    type_s      = type_q;
    cookie_ok_s = cookie_ok_q;
    seen_mt_s   = seen_mt_q;
    record_s    = 1'b0;
    if (pos_q >= POS_W'(MAX_PACKET_BYTES)) begin
      if (phase_q == PH_TYPE || phase_q == PH_LENGTH || phase_q == PH_DATA) begin
        phase_s = PH_OVERRUN;
      end
    end else begin
      pos_s = pos_q + POS_W'(1);
      unique case (phase_q)
        PH_HEADER: begin
          if (pos_q >= POS_W'(FIXED_HEADER_BYTES - 1)) begin
            phase_s = PH_COOKIE;
          end
        end
        PH_COOKIE: begin
          cookie_ok_s = cookie_ok_q && (b == cookie_byte(cookie_idx));
          if (cookie_idx == 2'(COOKIE_BYTES - 1)) begin
            phase_s = cookie_ok_s ? PH_TYPE : PH_DISCARD;
          end
        end
        PH_TYPE: begin
          if (b == CODE_END) begin
            phase_s = PH_DONE;
          end else if (b != CODE_PAD) begin
            type_s  = b;
            phase_s = PH_LENGTH;
            if (b == CODE_MESSAGE_TYPE) begin
              seen_mt_s = 1'b1;
            end
          end
        end
        PH_LENGTH: begin
          record_s = 1'b1;
          skip_s   = b;
          phase_s  = (b == 8'd0) ? PH_TYPE : PH_DATA;
        end
        PH_DATA: begin
          skip_s = skip_q - 8'd1;
          if (skip_s == 8'd0) begin
            phase_s = PH_TYPE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Next state: the last byte of a packet returns everything to the start.
  always_comb begin
    pos_d       = pos_q;
    phase_d     = phase_q;
    skip_d      = skip_q;
    type_d      = type_q;
    cookie_ok_d = cookie_ok_q;
    seen_mt_d   = seen_mt_q;
    if (in_accept) begin
      if (in_data_i.last_byte) begin
        pos_d       = '0;
        phase_d     = PH_HEADER;
        skip_d      = '0;
        type_d      = '0;
        cookie_ok_d = 1'b1;
        seen_mt_d   = 1'b0;
      end else begin
        pos_d       = pos_s;
        phase_d     = phase_s;
        skip_d      = skip_s;
        type_d      = type_s;
        cookie_ok_d = cookie_ok_s;
        seen_mt_d   = seen_mt_s;
      end
    end
  end

  // Result for the current byte: a verdict takes the place of any record.
  always_comb begin
    res           = '0;
    res.kind      = KIND_RECORD;
    res.verdict   = VERDICT_OK;
    res_valid     = 1'b0;
    if (in_accept) begin
      if (in_data_i.last_byte) begin
        res_valid = 1'b1;
        res.kind  = KIND_VERDICT;
        priority if (phase_s == PH_HEADER || phase_s == PH_COOKIE) begin
          res.verdict = VERDICT_TOO_SHORT;
        end else if (phase_s == PH_DISCARD || !cookie_ok_s) begin
          res.verdict = VERDICT_BAD_COOKIE;
        end else if (phase_s != PH_DONE) begin
          res.verdict = VERDICT_OVERRUN;
        end else if (!seen_mt_s) begin
          res.verdict = VERDICT_NO_MSG_TYPE;
        end else begin
          res.verdict = VERDICT_OK;
        end
      end else if (record_s) begin
        res_valid         = 1'b1;
        res.option_type   = type_q;
        res.option_length = b;
        res.data_offset   = OFFSET_W'(pos_q + POS_W'(1));
      end
    end
  end

  // Output register with one skid entry; the skid entry always holds the
  // result that follows the one in the output register.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (out_free) begin
      out_valid_d = res_valid;
      out_d       = res;
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      phase_q      <= PH_HEADER;
      skip_q       <= '0;
      type_q       <= '0;
      cookie_ok_q  <= 1'b1;
      seen_mt_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      phase_q      <= phase_d;
      skip_q       <= skip_d;
      type_q       <= type_d;
      cookie_ok_q  <= cookie_ok_d;
      seen_mt_q    <= seen_mt_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
